@@ rtl/mtf_pkg.sv @@
// Package for the move-to-front search list: list capacity, derived widths,
// transfer payload types, result status codes and controller command type.
// No dependencies.
`default_nettype none

package mtf_pkg;

    localparam int DEPTH = 16;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_APPENDED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_ZERO      = 3'd4
    } status_t;

    typedef enum logic {
        MODE_APPEND = 1'b0,
        MODE_SEARCH = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] value;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic [3:0] position;
        logic [4:0] count;
    } result_t;

    typedef struct packed {
        logic load_item;
        logic commit;
    } ctl_cmd_t;

endpackage

`default_nettype wire

@@ rtl/move_to_front_search_list_top.sv @@
// Top level of the move-to-front search list: controller plus datapath.
// Sequence: an item is captured in S_IDLE and executed in S_EXEC, where its
// result is registered on commit; commit waits while a result is stalled.
// Items: a new item stalls until the current one commits in the S_EXEC step
// in which the row of entry cells compares, shifts and updates the count.
// Reset: entry count zero and no result pending; entry contents are undefined.
// Depends on mtf_pkg, mtf_ctrl and mtf_datapath.
`default_nettype none

module move_to_front_search_list_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire mtf_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output mtf_pkg::result_t      result
);

    mtf_pkg::ctl_cmd_t cmd;

    mtf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    mtf_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .result (result)
    );

endmodule

`default_nettype wire

@@ rtl/mtf_ctrl.sv @@
// Controller for the move-to-front search list: sequences item capture,
// execution and the result handshake. Depends on mtf_pkg.
`default_nettype none

module mtf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output mtf_pkg::ctl_cmd_t     cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    always_comb
    begin
        cmd.load_item = item_valid && (state_reg == S_IDLE);
        cmd.commit    = (state_reg == S_EXEC) && (!result_valid_reg || !result_stall);
        state_next    = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.commit)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

@@ rtl/mtf_datapath.sv @@
// Datapath for the move-to-front search list: item register, the row of
// compare-and-shift entry cells, the entry count and the result register.
// Depends on mtf_pkg.
`default_nettype none

module mtf_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mtf_pkg::item_t    item,
    input  wire mtf_pkg::ctl_cmd_t cmd,
    output mtf_pkg::result_t       result
);

    localparam int DEPTH = mtf_pkg::DEPTH;
    localparam int PTR_W = mtf_pkg::PTR_W;
    localparam int CNT_W = mtf_pkg::CNT_W;

    mtf_pkg::item_t   item_reg;
    mtf_pkg::result_t result_reg;
    mtf_pkg::result_t result_next;
    logic [31:0]      entries_reg [DEPTH];
    logic [31:0]      entries_next [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [31:0]      item_bits;
    logic [DEPTH-1:0] match;
    logic             hit;
    logic [PTR_W-1:0] hit_pos;
    logic             is_zero;
    logic             is_full;
    logic             do_append;
    logic             do_move;
    logic [PTR_W+3:0] pos_ext;
    logic [CNT_W+4:0] count_ext;

    always_comb
    begin
        item_bits = $unsigned(item_reg.value);
        for (int i = 0; i < DEPTH; i++)
        begin
            match[i] = (CNT_W'(i) < count_reg) && (entries_reg[i] == item_bits);
        end
        hit     = |match;
        hit_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_pos = PTR_W'(i);
            end
        end

        is_zero   = (item_bits == 32'd0);
        is_full   = (count_reg == CNT_W'(DEPTH));
        do_append = !is_zero && (item_reg.mode == mtf_pkg::MODE_APPEND) && !is_full;
        do_move   = !is_zero && (item_reg.mode == mtf_pkg::MODE_SEARCH) && hit;

        for (int i = 0; i < DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (do_append && (CNT_W'(i) == count_reg))
            begin
                entries_next[i] = item_bits;
            end
            else if (do_move && (PTR_W'(i) <= hit_pos))
            begin
                entries_next[i] = (i == 0) ? item_bits : entries_reg[(i > 0) ? i - 1 : 0];
            end
        end
        count_next = do_append ? count_reg + CNT_W'(1) : count_reg;

        if (is_zero)
        begin
            result_next.status = mtf_pkg::ST_ZERO;
        end
        else if (item_reg.mode == mtf_pkg::MODE_APPEND)
        begin
            result_next.status = is_full ? mtf_pkg::ST_FULL : mtf_pkg::ST_APPENDED;
        end
        else
        begin
            result_next.status = hit ? mtf_pkg::ST_FOUND : mtf_pkg::ST_NOT_FOUND;
        end
        pos_ext              = (PTR_W + 4)'(do_move ? hit_pos : PTR_W'(0));
        count_ext            = (CNT_W + 5)'(count_next);
        result_next.position = pos_ext[3:0];
        result_next.count    = count_ext[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
            for (int i = 0; i < DEPTH; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
        end
    end

    assign result = result_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds capacity");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(count_reg))
        else $error("entry count changed without a commit");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (result_next.status == mtf_pkg::ST_APPENDED))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append did not advance the entry count");

    a_found_front: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (result_next.status == mtf_pkg::ST_FOUND))
        |=> (entries_reg[0] == $past(item_bits)))
        else $error("found entry did not move to the front");
`endif

endmodule

`default_nettype wire
